/* design/xmr_pkg.sv */
// ----------------------------------------------------------------------------
// xmr_pkg
// Shared constants and types of the XMODEM block receiver: symbols, command,
// verdict and status codes, register indexes and the configuration struct.
// ----------------------------------------------------------------------------
package xmr_pkg;

  localparam int DATA_BYTES = 128;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int CODE_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [BYTE_W-1:0] FIRST_CHECK_POS = BYTE_W'(DATA_BYTES + 2);

  localparam logic [BYTE_W-1:0] SYM_SOH = 8'h01;
  localparam logic [BYTE_W-1:0] SYM_EOT = 8'h04;
  localparam logic [BYTE_W-1:0] SYM_ACK = 8'h06;
  localparam logic [BYTE_W-1:0] SYM_NAK = 8'h15;
  localparam logic [BYTE_W-1:0] SYM_ETB = 8'h17;
  localparam logic [BYTE_W-1:0] SYM_CRC = 8'h43;

  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [CODE_W-1:0] VERDICT_NONE   = 2'd0;
  localparam logic [CODE_W-1:0] VERDICT_ACCEPT = 2'd1;
  localparam logic [CODE_W-1:0] VERDICT_REJECT = 2'd2;

  localparam logic [CODE_W-1:0] STATUS_IDLE     = 2'd0;
  localparam logic [CODE_W-1:0] STATUS_BUSY     = 2'd1;
  localparam logic [CODE_W-1:0] STATUS_FINISHED = 2'd2;
  localparam logic [CODE_W-1:0] STATUS_FAILED   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd1;

  localparam logic [BYTE_W-1:0] RETRY_LIMIT_RESET = 8'd10;

  typedef struct packed {
    logic              check_mode;
    logic [BYTE_W-1:0] retry_limit;
  } cfg_t;

endpackage

/* design/xmr_ifs.sv */
// ----------------------------------------------------------------------------
// xmr_ifs
// Channel interfaces: receive events in, protocol results out.
// ----------------------------------------------------------------------------
interface xmr_evt_if;
  import xmr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] rx_byte;
  modport source(output valid, command, rx_byte, input ready);
  modport sink(input valid, command, rx_byte, output ready);
endinterface

interface xmr_res_if;
  import xmr_pkg::*;
  logic              valid;
  logic              ready;
  logic              send_valid;
  logic [BYTE_W-1:0] send_byte;
  logic              data_valid;
  logic [BYTE_W-1:0] data_byte;
  logic [CODE_W-1:0] block_verdict;
  logic [CODE_W-1:0] transfer_status;
  modport source(output valid, send_valid, send_byte, data_valid, data_byte,
                 block_verdict, transfer_status, input ready);
  modport sink(input valid, send_valid, send_byte, data_valid, data_byte,
               block_verdict, transfer_status, output ready);
endinterface

/* design/xmr_check.sv */
// ----------------------------------------------------------------------------
// xmr_check
// Running block check update for one payload byte: 8-bit sum or
// CRC-16/XMODEM (polynomial 0x1021, MSB first).
// ----------------------------------------------------------------------------
module xmr_check (
  input  logic                       check_mode,
  input  logic [xmr_pkg::CRC_W-1:0]  cur,
  input  logic [xmr_pkg::BYTE_W-1:0] data,
  output logic [xmr_pkg::CRC_W-1:0]  nxt
);
  import xmr_pkg::*;

  logic [CRC_W-1:0]  crc;
  logic [BYTE_W-1:0] sum;

  always_comb begin
    crc = cur ^ {data, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      if (crc[CRC_W-1]) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ 16'h1021;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
  end

  assign sum = cur[BYTE_W-1:0] + data;
  assign nxt = check_mode ? crc : {8'h00, sum};

endmodule

/* design/xmr_core.sv */
// ----------------------------------------------------------------------------
// xmr_core
// Protocol state machine and result register. Each accepted event updates
// the transfer state and loads one result transaction.
// ----------------------------------------------------------------------------
module xmr_core (
  input  logic          clk,
  input  logic          rst,
  input  xmr_pkg::cfg_t cfg,
  xmr_evt_if.sink       evt,
  xmr_res_if.source     res
);
  import xmr_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_INIT  = 3'd1;
  localparam logic [2:0] PH_GAP   = 3'd2;
  localparam logic [2:0] PH_BLOCK = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [2:0] PH_FAIL  = 3'd5;

  logic [2:0]        phase, phase_next;
  logic [BYTE_W-1:0] attempts, attempts_next;
  logic [BYTE_W-1:0] expected, expected_next;
  logic [BYTE_W-1:0] pos, pos_next;
  logic              header_ok, header_ok_next;
  logic [BYTE_W-1:0] seen, seen_next;
  logic [CRC_W-1:0]  run, run_next;
  logic [CRC_W-1:0]  rcv, rcv_next;

  logic              out_valid;
  logic              send_valid, send_valid_next;
  logic [BYTE_W-1:0] send_byte, send_byte_next;
  logic              data_valid, data_valid_next;
  logic [BYTE_W-1:0] data_byte, data_byte_next;
  logic [CODE_W-1:0] verdict, verdict_next;
  logic [CODE_W-1:0] status, status_next;

  logic              acc;
  logic [CRC_W-1:0]  run_upd;
  logic [BYTE_W-1:0] last_pos;
  logic [BYTE_W-1:0] init_sym;
  logic [CRC_W-1:0]  rcv_full;
  logic              check_ok;
  logic              block_ok;

  xmr_check u_check (
    .check_mode(cfg.check_mode),
    .cur       (run),
    .data      (evt.rx_byte),
    .nxt       (run_upd)
  );

  assign evt.ready = !out_valid || res.ready;
  assign acc       = evt.valid && evt.ready;

  assign last_pos = FIRST_CHECK_POS + {7'd0, cfg.check_mode};
  assign init_sym = cfg.check_mode ? SYM_CRC : SYM_NAK;
  assign rcv_full = {rcv[CRC_W-1:BYTE_W], evt.rx_byte};
  assign check_ok = cfg.check_mode ? (run == rcv_full) : (run[BYTE_W-1:0] == evt.rx_byte);
  assign block_ok = header_ok && check_ok;

  always_comb begin
    phase_next      = phase;
    attempts_next   = attempts;
    expected_next   = expected;
    pos_next        = pos;
    header_ok_next  = header_ok;
    seen_next       = seen;
    run_next        = run;
    rcv_next        = rcv;
    send_valid_next = 1'b0;
    send_byte_next  = 8'h00;
    data_valid_next = 1'b0;
    data_byte_next  = 8'h00;
    verdict_next    = VERDICT_NONE;

    if (evt.command == CMD_START) begin
      phase_next      = PH_INIT;
      attempts_next   = 8'd1;
      expected_next   = 8'd1;
      pos_next        = 8'd0;
      header_ok_next  = 1'b0;
      seen_next       = 8'd0;
      run_next        = 16'd0;
      rcv_next        = 16'd0;
      send_valid_next = 1'b1;
      send_byte_next  = init_sym;
    end else begin
      case (phase)
        PH_INIT: begin
          if (evt.command == CMD_TIMEOUT) begin
            if (attempts < cfg.retry_limit) begin
              attempts_next   = attempts + 8'd1;
              send_valid_next = 1'b1;
              send_byte_next  = init_sym;
            end else begin
              phase_next = PH_FAIL;
            end
          end else if (evt.command == CMD_BYTE) begin
            if (evt.rx_byte == SYM_SOH) begin
              phase_next     = PH_BLOCK;
              pos_next       = 8'd0;
              header_ok_next = 1'b0;
              seen_next      = 8'd0;
              run_next       = 16'd0;
              rcv_next       = 16'd0;
            end else begin
              phase_next = PH_FAIL;
            end
          end
        end
        PH_GAP: begin
          if (evt.command == CMD_BYTE) begin
            if (evt.rx_byte == SYM_SOH) begin
              phase_next     = PH_BLOCK;
              pos_next       = 8'd0;
              header_ok_next = 1'b0;
              seen_next      = 8'd0;
              run_next       = 16'd0;
              rcv_next       = 16'd0;
            end else if (evt.rx_byte == SYM_EOT || evt.rx_byte == SYM_ETB) begin
              send_valid_next = 1'b1;
              send_byte_next  = SYM_ACK;
              phase_next      = PH_DONE;
            end else begin
              phase_next = PH_FAIL;
            end
          end
        end
        PH_BLOCK: begin
          if (evt.command == CMD_BYTE) begin
            pos_next = pos + 8'd1;
            if (pos == 8'd0) begin
              seen_next = evt.rx_byte;
            end else if (pos == 8'd1) begin
              header_ok_next = (seen == expected) &&
                               (({1'b0, seen} + {1'b0, evt.rx_byte}) == 9'd255);
            end else if (pos < FIRST_CHECK_POS) begin
              data_valid_next = 1'b1;
              data_byte_next  = evt.rx_byte;
              run_next        = run_upd;
            end else if (pos >= last_pos) begin
              rcv_next        = cfg.check_mode ? rcv_full : {8'h00, evt.rx_byte};
              send_valid_next = 1'b1;
              phase_next      = PH_GAP;
              pos_next        = 8'd0;
              if (block_ok) begin
                send_byte_next = SYM_ACK;
                verdict_next   = VERDICT_ACCEPT;
                expected_next  = expected + 8'd1;
              end else begin
                send_byte_next = SYM_NAK;
                verdict_next   = VERDICT_REJECT;
              end
            end else begin
              rcv_next = {evt.rx_byte, 8'h00};
            end
          end
        end
        default: begin
        end
      endcase
    end

    case (phase_next)
      PH_IDLE: status_next = STATUS_IDLE;
      PH_DONE: status_next = STATUS_FINISHED;
      PH_FAIL: status_next = STATUS_FAILED;
      default: status_next = STATUS_BUSY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      attempts  <= 8'd0;
      expected  <= 8'd1;
      pos       <= 8'd0;
      header_ok <= 1'b0;
      seen      <= 8'd0;
      run       <= 16'd0;
      rcv       <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        phase     <= phase_next;
        attempts  <= attempts_next;
        expected  <= expected_next;
        pos       <= pos_next;
        header_ok <= header_ok_next;
        seen      <= seen_next;
        run       <= run_next;
        rcv       <= rcv_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      send_valid <= send_valid_next;
      send_byte  <= send_byte_next;
      data_valid <= data_valid_next;
      data_byte  <= data_byte_next;
      verdict    <= verdict_next;
      status     <= status_next;
    end
  end

  assign res.valid           = out_valid;
  assign res.send_valid      = send_valid;
  assign res.send_byte       = send_byte;
  assign res.data_valid      = data_valid;
  assign res.data_byte       = data_byte;
  assign res.block_verdict   = verdict;
  assign res.transfer_status = status;

  a_verdict_sends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict != VERDICT_NONE) |-> send_valid)
    else $error("block verdict without a send symbol");

  a_data_no_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(data_valid && verdict != VERDICT_NONE))
    else $error("payload byte and verdict in one transaction");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BLOCK |-> pos <= FIRST_CHECK_POS + 8'd1)
    else $error("byte position past the check field");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (acc && evt.command == CMD_START) |=>
      (out_valid && send_valid && status == STATUS_BUSY && phase == PH_INIT))
    else $error("start did not open a transfer");

endmodule

/* design/xmodem_block_receiver.sv */
// ----------------------------------------------------------------------------
// xmodem_block_receiver
// XMODEM receive side: init symbol and retries, block header and check
// verification (8-bit sum or CRC-16/XMODEM), payload streaming, ACK/NAK.
//
//   channel  dir   transaction
//   evt      in    command, rx_byte (start, received byte, timeout)
//   res      out   send_valid/byte, data_valid/byte, block_verdict, status
//   cfg_*    in    write of check_mode (index 0) or retry_limit (index 1)
//
// One event per cycle unless a result stalls; each result is registered.
// The output register frees when res.ready is high, so evt.ready follows it.
// A stalled result holds; the next event is taken in the cycle it leaves.
// Reset is synchronous: idle, checksum mode, retry limit of 10.
// ----------------------------------------------------------------------------
module xmodem_block_receiver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [xmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xmr_pkg::CFG_DATA_W-1:0] cfg_data,
  xmr_evt_if.sink                        evt,
  xmr_res_if.source                      res
);
  import xmr_pkg::*;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_mode  <= 1'b0;
      cfg.retry_limit <= RETRY_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHECK_MODE:  cfg.check_mode  <= cfg_data[0];
        REG_RETRY_LIMIT: cfg.retry_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  xmr_core u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .evt(evt),
    .res(res)
  );

endmodule
